/* rtl/obb_sat_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// obb_sat_pkg
// Shared constants and the arctangent table of the
// oriented-box separating axis test.
// ----------------------------------------------------------------------------
package obb_sat_pkg;

    localparam int COORD_BITS_DEF    = 24;
    localparam int ANGLE_BITS_DEF    = 16;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int NORM_BITS         = 16;
    localparam int MAX_STAGES        = 24;

    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    // Arctangent of 2^-i in turns scaled by 2^32.
    function automatic logic signed [33:0] atan_turn(input int i);
        logic signed [33:0] r;
        begin
            r = '0;
            case (i)
                0:  r = 34'sh020000000;
                1:  r = 34'sh012E4051E;
                2:  r = 34'sh009FB385B;
                3:  r = 34'sh0051111D4;
                4:  r = 34'sh0028B0D43;
                5:  r = 34'sh00145D7E1;
                6:  r = 34'sh000A2F61E;
                7:  r = 34'sh000517C55;
                8:  r = 34'sh00028BE53;
                9:  r = 34'sh000145F2F;
                10: r = 34'sh0000A2F98;
                11: r = 34'sh0000517CC;
                12: r = 34'sh000028BE6;
                13: r = 34'sh0000145F3;
                14: r = 34'sh00000A2FA;
                15: r = 34'sh00000517D;
                16: r = 34'sh0000028BE;
                17: r = 34'sh00000145F;
                18: r = 34'sh000000A30;
                19: r = 34'sh000000518;
                20: r = 34'sh00000028C;
                21: r = 34'sh000000146;
                22: r = 34'sh0000000A3;
                23: r = 34'sh000000051;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

/* rtl/obb_sat_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// obb_sat_in_if / obb_sat_out_if
// Valid/ready channels that carry one box pair and one test result.
// ----------------------------------------------------------------------------
interface obb_sat_in_if #(
    parameter int COORD_BITS = 24,
    parameter int ANGLE_BITS = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [COORD_BITS-1:0]   a_center_x;
    logic signed [COORD_BITS-1:0]   a_center_y;
    logic        [COORD_BITS-2:0]   a_width;
    logic        [COORD_BITS-2:0]   a_height;
    logic        [ANGLE_BITS-1:0]   a_angle;
    logic signed [COORD_BITS-1:0]   b_center_x;
    logic signed [COORD_BITS-1:0]   b_center_y;
    logic        [COORD_BITS-2:0]   b_width;
    logic        [COORD_BITS-2:0]   b_height;
    logic        [ANGLE_BITS-1:0]   b_angle;

    modport source (output valid, a_center_x, a_center_y, a_width, a_height, a_angle,
                    b_center_x, b_center_y, b_width, b_height, b_angle, input ready);
    modport sink (input valid, a_center_x, a_center_y, a_width, a_height, a_angle,
                  b_center_x, b_center_y, b_width, b_height, b_angle, output ready);
endinterface

interface obb_sat_out_if #(
    parameter int COORD_BITS = 24
);
    logic                           valid;
    logic                           ready;
    logic                           hit;
    logic signed [15:0]             normal_x;
    logic signed [15:0]             normal_y;
    logic        [COORD_BITS-2:0]   depth;
    logic signed [COORD_BITS-1:0]   contact_x;
    logic signed [COORD_BITS-1:0]   contact_y;

    modport source (output valid, hit, normal_x, normal_y, depth, contact_x, contact_y,
                    input ready);
    modport sink (input valid, hit, normal_x, normal_y, depth, contact_x, contact_y,
                  output ready);
endinterface
`default_nettype wire

/* rtl/obb_sat_cordic.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// obb_sat_cordic
// Pipelined CORDIC rotator: one stage per iteration, Q1.14 cos/sin out.
// ----------------------------------------------------------------------------
module obb_sat_cordic #(
    parameter int ANGLE_BITS    = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic                  clk,
    input  wire logic                  en,
    input  wire logic [ANGLE_BITS-1:0] angle,
    output logic signed [15:0]         cos_q14,
    output logic signed [15:0]         sin_q14
);
    import obb_sat_pkg::*;

    logic signed [33:0] x_reg [CORDIC_STAGES+1];
    logic signed [33:0] y_reg [CORDIC_STAGES+1];
    logic signed [33:0] z_reg [CORDIC_STAGES+1];
    logic               neg_reg [CORDIC_STAGES+1];

    logic [31:0] a_full;
    logic [31:0] a_fold;
    logic        neg_next;

    always_comb
    begin
        a_full   = {angle, {(32-ANGLE_BITS){1'b0}}};
        neg_next = (a_full + 32'h4000_0000) >= 32'h8000_0000;
        a_fold   = neg_next ? (a_full - 32'h8000_0000) : a_full;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]   <= CORDIC_GAIN;
            y_reg[0]   <= '0;
            z_reg[0]   <= {{2{a_fold[31]}}, a_fold};
            neg_reg[0] <= neg_next;
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
        logic signed [33:0] dx;
        logic signed [33:0] dy;
        assign dx = x_reg[i] >>> i;
        assign dy = y_reg[i] >>> i;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[i][33])
                begin
                    x_reg[i+1] <= x_reg[i] - dy;
                    y_reg[i+1] <= y_reg[i] + dx;
                    z_reg[i+1] <= z_reg[i] - atan_turn(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + dy;
                    y_reg[i+1] <= y_reg[i] - dx;
                    z_reg[i+1] <= z_reg[i] + atan_turn(i);
                end
                neg_reg[i+1] <= neg_reg[i];
            end
        end
    end

    logic signed [33:0] xf;
    logic signed [33:0] yf;
    logic signed [33:0] xr;
    logic signed [33:0] yr;

    always_comb
    begin
        xf = neg_reg[CORDIC_STAGES] ? -x_reg[CORDIC_STAGES] : x_reg[CORDIC_STAGES];
        yf = neg_reg[CORDIC_STAGES] ? -y_reg[CORDIC_STAGES] : y_reg[CORDIC_STAGES];
        xr = (xf + 34'sd32768) >>> 16;
        yr = (yf + 34'sd32768) >>> 16;
        cos_q14 = (xr > 34'sd16384) ? 16'sd16384 :
                  (xr < -34'sd16384) ? -16'sd16384 : xr[15:0];
        sin_q14 = (yr > 34'sd16384) ? 16'sd16384 :
                  (yr < -34'sd16384) ? -16'sd16384 : yr[15:0];
    end

endmodule
`default_nettype wire

/* rtl/obb_sat_axis.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// obb_sat_axis
// Projects both boxes and the center offset onto one axis over three
// register stages and gives the overlap in Q.21.
// ----------------------------------------------------------------------------
module obb_sat_axis #(
    parameter int COORD_BITS = 24
) (
    input  wire logic                         clk,
    input  wire logic                         en,
    input  wire logic signed [15:0]           nx,
    input  wire logic signed [15:0]           ny,
    input  wire logic signed [15:0]           ac,
    input  wire logic signed [15:0]           as_,
    input  wire logic signed [15:0]           bc,
    input  wire logic signed [15:0]           bs,
    input  wire logic        [COORD_BITS-2:0] aw,
    input  wire logic        [COORD_BITS-2:0] ah,
    input  wire logic        [COORD_BITS-2:0] bw,
    input  wire logic        [COORD_BITS-2:0] bh,
    input  wire logic signed [COORD_BITS:0]   dx,
    input  wire logic signed [COORD_BITS:0]   dy,
    output logic signed [COORD_BITS+39:0]     ov
);
    localparam int OW = COORD_BITS + 40;

    // stage 1: axis dot products, raw Q2.28 terms and distance terms
    logic signed [31:0] p_reg [8];
    logic signed [COORD_BITS+16:0] e0_reg, e1_reg;
    logic [COORD_BITS-2:0] aw_reg, ah_reg, bw_reg, bh_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0] <= 32'(nx * ac);  p_reg[1] <= 32'(ny * as_);
            p_reg[2] <= 32'(-(nx * as_)); p_reg[3] <= 32'(ny * ac);
            p_reg[4] <= 32'(nx * bc);  p_reg[5] <= 32'(ny * bs);
            p_reg[6] <= 32'(-(nx * bs)); p_reg[7] <= 32'(ny * bc);
            e0_reg <= (COORD_BITS+17)'(dx * nx);
            e1_reg <= (COORD_BITS+17)'(dy * ny);
            aw_reg <= aw; ah_reg <= ah; bw_reg <= bw; bh_reg <= bh;
        end
    end

    function automatic logic [23:0] dot_abs(input logic signed [31:0] p,
                                            input logic signed [31:0] q);
        logic signed [32:0] s;
        logic signed [32:0] r;
        begin
            s = 33'(p) + 33'(q) + 33'sd128;
            r = s >>> 8;
            dot_abs = r[32] ? 24'(-r) : r[23:0];
        end
    endfunction

    // stage 2: radius products, distance magnitude
    logic [COORD_BITS+22:0] m_reg [4];
    logic [COORD_BITS+17:0] dist_reg;
    logic signed [COORD_BITS+17:0] dist_s;

    assign dist_s = (COORD_BITS+18)'(e0_reg) + (COORD_BITS+18)'(e1_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg[0] <= (COORD_BITS+23)'(aw_reg * dot_abs(p_reg[0], p_reg[1]));
            m_reg[1] <= (COORD_BITS+23)'(ah_reg * dot_abs(p_reg[2], p_reg[3]));
            m_reg[2] <= (COORD_BITS+23)'(bw_reg * dot_abs(p_reg[4], p_reg[5]));
            m_reg[3] <= (COORD_BITS+23)'(bh_reg * dot_abs(p_reg[6], p_reg[7]));
            dist_reg <= dist_s[COORD_BITS+17] ? (COORD_BITS+18)'(-dist_s)
                                              : (COORD_BITS+18)'(dist_s);
        end
    end

    // stage 3: overlap
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ov <= OW'(m_reg[0]) + OW'(m_reg[1]) + OW'(m_reg[2]) + OW'(m_reg[3])
                  - (OW'(dist_reg) <<< 7);
        end
    end

endmodule
`default_nettype wire

/* rtl/oriented_box_sat_mtv.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// oriented_box_sat_mtv
// Separating axis test of two oriented boxes with minimum translation vector.
// ----------------------------------------------------------------------------
// Takes one box pair per cycle unless the output stalls, and gives one result
// per pair, in order. The pipeline has one CORDIC stage per iteration,
// three stages of axis projection, then axis selection, depth rounding,
// contact product and saturation. The whole pipeline advances when the
// output register is empty or taken; a stall holds every stage.
module oriented_box_sat_mtv
    import obb_sat_pkg::*;
#(
    parameter int COORD_BITS    = COORD_BITS_DEF,
    parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    obb_sat_in_if.sink   in_ch,
    obb_sat_out_if.source out_ch
);
    localparam int CB = COORD_BITS;
    localparam int OW = CB + 40;
    localparam int DLY = CORDIC_STAGES + 1;   // depth of the geometry delay line, aligned with cos/sin
    localparam int LAT = DLY + 7;             // depth of the valid shift register up to the output register

    logic en;
    logic [LAT-1:0] vld_reg;

    assign en = !out_ch.valid || out_ch.ready;
    assign in_ch.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], in_ch.valid};
    end
    assign out_ch.valid = vld_reg[LAT-1];

    // geometry delayed alongside the CORDIC
    logic signed [CB-1:0] acx_d [DLY], acy_d [DLY], bcx_d [DLY], bcy_d [DLY];
    logic [CB-2:0] aw_d [DLY], ah_d [DLY], bw_d [DLY], bh_d [DLY];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acx_d[0] <= in_ch.a_center_x; acy_d[0] <= in_ch.a_center_y;
            bcx_d[0] <= in_ch.b_center_x; bcy_d[0] <= in_ch.b_center_y;
            aw_d[0] <= in_ch.a_width; ah_d[0] <= in_ch.a_height;
            bw_d[0] <= in_ch.b_width; bh_d[0] <= in_ch.b_height;
            for (int i = 1; i < DLY; i++)
            begin
                acx_d[i] <= acx_d[i-1]; acy_d[i] <= acy_d[i-1];
                bcx_d[i] <= bcx_d[i-1]; bcy_d[i] <= bcy_d[i-1];
                aw_d[i] <= aw_d[i-1]; ah_d[i] <= ah_d[i-1];
                bw_d[i] <= bw_d[i-1]; bh_d[i] <= bh_d[i-1];
            end
        end
    end

    logic signed [15:0] ca, sa, cb, sb, nsa, nsb;
    obb_sat_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_cor_a (
        .clk(clk), .en(en), .angle(in_ch.a_angle), .cos_q14(ca), .sin_q14(sa));
    obb_sat_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_cor_b (
        .clk(clk), .en(en), .angle(in_ch.b_angle), .cos_q14(cb), .sin_q14(sb));
    assign nsa = -sa;
    assign nsb = -sb;

    logic signed [CB:0] dx, dy;
    assign dx = (CB+1)'(bcx_d[DLY-1]) - (CB+1)'(acx_d[DLY-1]);
    assign dy = (CB+1)'(bcy_d[DLY-1]) - (CB+1)'(acy_d[DLY-1]);

    logic signed [15:0] axn_x [4], axn_y [4];
    assign axn_x[0] = ca;  assign axn_y[0] = sa;
    assign axn_x[1] = nsa; assign axn_y[1] = ca;
    assign axn_x[2] = cb;  assign axn_y[2] = sb;
    assign axn_x[3] = nsb; assign axn_y[3] = cb;

    logic signed [OW-1:0] ov [4];
    for (genvar k = 0; k < 4; k++) begin : g_axis
        obb_sat_axis #(.COORD_BITS(CB)) u_axis (
            .clk(clk), .en(en), .nx(axn_x[k]), .ny(axn_y[k]),
            .ac(ca), .as_(sa), .bc(cb), .bs(sb),
            .aw(aw_d[DLY-1]), .ah(ah_d[DLY-1]), .bw(bw_d[DLY-1]), .bh(bh_d[DLY-1]),
            .dx(dx), .dy(dy), .ov(ov[k]));
    end

    // carry axes, offset and center sums through the three projection stages
    logic signed [15:0] nxq [3][4], nyq [3][4];
    logic signed [CB:0] dxq [3], dyq [3], sxq [3], syq [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
            begin
                nxq[0][k] <= axn_x[k]; nyq[0][k] <= axn_y[k];
                nxq[1][k] <= nxq[0][k]; nyq[1][k] <= nyq[0][k];
                nxq[2][k] <= nxq[1][k]; nyq[2][k] <= nyq[1][k];
            end
            dxq[0] <= dx; dyq[0] <= dy;
            sxq[0] <= (CB+1)'(acx_d[DLY-1]) + (CB+1)'(bcx_d[DLY-1]);
            syq[0] <= (CB+1)'(acy_d[DLY-1]) + (CB+1)'(bcy_d[DLY-1]);
            for (int i = 1; i < 3; i++)
            begin
                dxq[i] <= dxq[i-1]; dyq[i] <= dyq[i-1];
                sxq[i] <= sxq[i-1]; syq[i] <= syq[i-1];
            end
        end
    end

    // select: least overlap, first wins ties; miss if any overlap is negative
    logic               sel_hit;
    logic [1:0]         sel_k;
    logic signed [OW-1:0] sel_ov;
    always_comb
    begin
        sel_hit = 1'b1;
        sel_k = 2'd0;
        sel_ov = ov[0];
        for (int k = 0; k < 4; k++)
        begin
            if (ov[k] < 0)
                sel_hit = 1'b0;
            if (ov[k] < sel_ov)
            begin
                sel_ov = ov[k];
                sel_k = 2'(k);
            end
        end
    end

    logic               s1_hit_reg;
    logic signed [OW-1:0] s1_ov_reg;
    logic signed [15:0] s1_nx_reg, s1_ny_reg;
    logic signed [CB:0] s1_dx_reg, s1_dy_reg, s1_sx_reg, s1_sy_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_hit_reg <= sel_hit;
            s1_ov_reg <= sel_ov;
            s1_nx_reg <= nxq[2][sel_k]; s1_ny_reg <= nyq[2][sel_k];
            s1_dx_reg <= dxq[2]; s1_dy_reg <= dyq[2];
            s1_sx_reg <= sxq[2]; s1_sy_reg <= syq[2];
        end
    end

    // offset along the normal and depth rounding
    logic               s2_hit_reg;
    logic [CB-2:0]      s2_depth_reg;
    logic signed [15:0] s2_nx_reg, s2_ny_reg;
    logic signed [CB+16:0] s2_ex_reg, s2_ey_reg;
    logic signed [CB:0] s2_sx_reg, s2_sy_reg;
    logic signed [OW-1:0] dep_r;

    assign dep_r = (s1_ov_reg + (OW'(1) <<< 20)) >>> 21;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_hit_reg <= s1_hit_reg;
            s2_depth_reg <= (dep_r < 0) ? '0 :
                            (dep_r > OW'({(CB-1){1'b1}})) ? {(CB-1){1'b1}} : dep_r[CB-2:0];
            s2_nx_reg <= s1_nx_reg; s2_ny_reg <= s1_ny_reg;
            s2_ex_reg <= (CB+17)'(s1_dx_reg * s1_nx_reg);
            s2_ey_reg <= (CB+17)'(s1_dy_reg * s1_ny_reg);
            s2_sx_reg <= s1_sx_reg; s2_sy_reg <= s1_sy_reg;
        end
    end

    // flip and contact products
    logic signed [CB+17:0] dsum;
    logic signed [15:0] fnx, fny;
    assign dsum = (CB+18)'(s2_ex_reg) + (CB+18)'(s2_ey_reg);
    assign fnx = dsum[CB+17] ? -s2_nx_reg : s2_nx_reg;
    assign fny = dsum[CB+17] ? -s2_ny_reg : s2_ny_reg;

    localparam int PW = CB + 18;
    localparam logic signed [PW:0] CMAX_W = $signed({{(PW-CB+2){1'b0}}, {(CB-1){1'b1}}});
    logic               s3_hit_reg;
    logic [CB-2:0]      s3_depth_reg;
    logic signed [15:0] s3_nx_reg, s3_ny_reg;
    logic signed [PW-1:0] s3_px_reg, s3_py_reg;
    logic signed [CB:0] s3_sx_reg, s3_sy_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_hit_reg <= s2_hit_reg;
            s3_depth_reg <= s2_depth_reg;
            s3_nx_reg <= fnx; s3_ny_reg <= fny;
            s3_px_reg <= PW'(fnx * $signed({1'b0, s2_depth_reg}));
            s3_py_reg <= PW'(fny * $signed({1'b0, s2_depth_reg}));
            s3_sx_reg <= s2_sx_reg; s3_sy_reg <= s2_sy_reg;
        end
    end

    logic signed [PW:0] cxw, cyw, cxr, cyr;
    logic signed [CB-1:0] cxs, cys;
    always_comb
    begin
        cxw = ((PW+1)'(s3_sx_reg) <<< 14) - (PW+1)'(s3_px_reg);
        cyw = ((PW+1)'(s3_sy_reg) <<< 14) - (PW+1)'(s3_py_reg);
        cxr = (cxw + (PW+1)'(16384)) >>> 15;
        cyr = (cyw + (PW+1)'(16384)) >>> 15;
        cxs = (cxr > CMAX_W) ? {1'b0, {(CB-1){1'b1}}} :
              (cxr < -((PW+1)'(1) <<< (CB-1))) ? {1'b1, {(CB-1){1'b0}}} : cxr[CB-1:0];
        cys = (cyr > CMAX_W) ? {1'b0, {(CB-1){1'b1}}} :
              (cyr < -((PW+1)'(1) <<< (CB-1))) ? {1'b1, {(CB-1){1'b0}}} : cyr[CB-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_ch.hit <= s3_hit_reg;
            out_ch.normal_x <= s3_hit_reg ? s3_nx_reg : '0;
            out_ch.normal_y <= s3_hit_reg ? s3_ny_reg : '0;
            out_ch.depth <= s3_hit_reg ? s3_depth_reg : '0;
            out_ch.contact_x <= s3_hit_reg ? cxs : '0;
            out_ch.contact_y <= s3_hit_reg ? cys : '0;
        end
    end

`ifndef ASSERT_OFF
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.hit) |-> (out_ch.depth == '0 && out_ch.normal_x == '0))
        else $error("miss result carries nonzero payload");
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.depth)))
        else $error("stalled result changed");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_ch.valid |-> in_ch.ready)
        else $error("input blocked with empty output");
`endif

endmodule
`default_nettype wire

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Oriented box pair collision test: random and directed box pairs are driven
// through the valid/ready input channel, each result is compared as a whole
// against a bit-exact CORDIC/SAT predictor held in the bench.
// ----------------------------------------------------------------------------
module tb;
    import obb_sat_pkg::*;

    localparam int CB = 24;
    localparam int AB = 16;
    localparam int STAGES = 16;
    localparam int LATENCY = STAGES + 8;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam longint CMAX = (64'sd1 <<< (CB - 1)) - 1;

    typedef struct packed {
        logic signed [CB-1:0] a_cx;
        logic signed [CB-1:0] a_cy;
        logic [CB-2:0]        a_w;
        logic [CB-2:0]        a_h;
        logic [AB-1:0]        a_ang;
        logic signed [CB-1:0] b_cx;
        logic signed [CB-1:0] b_cy;
        logic [CB-2:0]        b_w;
        logic [CB-2:0]        b_h;
        logic [AB-1:0]        b_ang;
    } box_pair_t;

    typedef struct packed {
        logic                 hit;
        logic signed [15:0]   nx;
        logic signed [15:0]   ny;
        logic [CB-2:0]        depth;
        logic signed [CB-1:0] cx;
        logic signed [CB-1:0] cy;
    } contact_t;

    logic clk;
    logic rst_n;

    obb_sat_in_if #(.COORD_BITS(CB), .ANGLE_BITS(AB)) in_ch ();
    obb_sat_out_if #(.COORD_BITS(CB)) out_ch ();

    oriented_box_sat_mtv #(
        .COORD_BITS(CB),
        .ANGLE_BITS(AB),
        .CORDIC_STAGES(STAGES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .out_ch(out_ch)
    );

    box_pair_t pending_pairs[$];
    contact_t  expected_contacts[$];
    int        mismatches;
    int        hits_seen;
    int        results_seen;
    int        idle_cycles;
    bit        stim_done;
    bit        hold_sender;
    int        send_gap;
    int        take_gap;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic void queue_pair(box_pair_t p);
        pending_pairs.insert(pending_pairs.size(), p);
    endfunction

    function automatic longint arsh(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_sh(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint atan_step(int i);
        longint t [24];
        t = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
              64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
              64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
              64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
              64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};
        return t[i];
    endfunction

    // Unit axis of a turn angle, Q1.14.
    task automatic rotate_unit(input logic [AB-1:0] ang, output longint c,
                               output longint s);
        logic [31:0] a;
        logic [31:0] q;
        bit     flip;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        a = {ang, {(32 - AB){1'b0}}};
        flip = 1'b0;
        x = 652032874;
        y = 0;
        q = a + 32'h40000000;
        if (q >= 32'h80000000)
        begin
            a = a - 32'h80000000;
            flip = 1'b1;
        end
        z = a[31] ? longint'(a) - 64'sh100000000 : longint'(a);
        for (int i = 0; i < STAGES; i++)
        begin
            dx = arsh(y, i);
            dy = arsh(x, i);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= atan_step(i);
            end
            else
            begin
                x += dx; y -= dy; z += atan_step(i);
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        c = clip(round_sh(x, 16), -16384, 16384);
        s = clip(round_sh(y, 16), -16384, 16384);
    endtask

    function automatic longint proj(longint px, longint py, longint qx, longint qy);
        return mag(round_sh(px * qx + py * qy, 8));
    endfunction

    task automatic predict_contact(input box_pair_t p, output contact_t r);
        longint axx [4];
        longint axy [4];
        longint c;
        longint s;
        longint dx;
        longint dy;
        longint ra;
        longint rb;
        longint ov;
        longint d_along;
        longint best_ov;
        longint nx;
        longint ny;
        longint dep;
        longint cx;
        longint cy;
        int     best;
        bit     sep;
        r = '0;
        best = 0;
        best_ov = 0;
        sep = 1'b0;
        rotate_unit(p.a_ang, c, s);
        axx[0] = c;  axy[0] = s;  axx[1] = -s; axy[1] = c;
        rotate_unit(p.b_ang, c, s);
        axx[2] = c;  axy[2] = s;  axx[3] = -s; axy[3] = c;
        dx = longint'(p.b_cx) - longint'(p.a_cx);
        dy = longint'(p.b_cy) - longint'(p.a_cy);
        for (int k = 0; k < 4; k++)
        begin
            if (!sep)
            begin
                ra = longint'(p.a_w) * proj(axx[k], axy[k], axx[0], axy[0])
                   + longint'(p.a_h) * proj(axx[k], axy[k], axx[1], axy[1]);
                rb = longint'(p.b_w) * proj(axx[k], axy[k], axx[2], axy[2])
                   + longint'(p.b_h) * proj(axx[k], axy[k], axx[3], axy[3]);
                d_along = dx * axx[k] + dy * axy[k];
                ov = ra + rb - mag(d_along) * 128;
                if (ov < 0)
                    sep = 1'b1;
                else if (k == 0 || ov < best_ov)
                begin
                    best_ov = ov;
                    best = k;
                end
            end
        end
        if (!sep)
        begin
            nx = axx[best];
            ny = axy[best];
            if (dx * nx + dy * ny < 0)
            begin
                nx = -nx;
                ny = -ny;
            end
            dep = clip(round_sh(best_ov, 21), 0, CMAX);
            cx = (longint'(p.a_cx) + longint'(p.b_cx)) * 16384 - nx * dep;
            cy = (longint'(p.a_cy) + longint'(p.b_cy)) * 16384 - ny * dep;
            r.hit = 1'b1;
            r.nx = nx[15:0];
            r.ny = ny[15:0];
            r.depth = dep[CB-2:0];
            r.cx = CB'(clip(round_sh(cx, 15), -CMAX - 1, CMAX));
            r.cy = CB'(clip(round_sh(cy, 15), -CMAX - 1, CMAX));
        end
    endtask

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [CB-2:0] rand_size(bit huge);
        if (huge)
            return (CB-1)'($urandom());
        case ($urandom_range(0, 3))
            0: return (CB-1)'($urandom_range(0, 255));
            1: return (CB-1)'($urandom_range(0, 8191));
            2: return (CB-1)'($urandom_range(0, 262143));
            default: return (CB-1)'($urandom());
        endcase
    endfunction

    function automatic box_pair_t rand_pair();
        box_pair_t p;
        int        spread;
        p.a_cx = CB'($urandom());
        p.a_cy = CB'($urandom());
        p.a_w = rand_size(1'b0);
        p.a_h = rand_size(1'b0);
        p.a_ang = AB'($urandom());
        p.b_w = rand_size(1'b0);
        p.b_h = rand_size(1'b0);
        p.b_ang = AB'($urandom());
        // Place B near A most of the time so overlaps and near misses both occur.
        if ($urandom_range(0, 3) != 0)
        begin
            spread = 32'(p.a_w) + 32'(p.b_w) + 32'(p.a_h) + 32'(p.b_h) + 1;
            p.b_cx = p.a_cx + CB'($signed($urandom_range(0, spread)) - spread / 2);
            p.b_cy = p.a_cy + CB'($signed($urandom_range(0, spread)) - spread / 2);
        end
        else
        begin
            p.b_cx = CB'($urandom());
            p.b_cy = CB'($urandom());
        end
        return p;
    endfunction

    function automatic box_pair_t simple_pair(int acx, int acy, int aw, int ah, int aang,
                                              int bcx, int bcy, int bw, int bh, int bang);
        box_pair_t p;
        p.a_cx = CB'(acx); p.a_cy = CB'(acy); p.a_w = (CB-1)'(aw); p.a_h = (CB-1)'(ah);
        p.a_ang = AB'(aang);
        p.b_cx = CB'(bcx); p.b_cy = CB'(bcy); p.b_w = (CB-1)'(bw); p.b_h = (CB-1)'(bh);
        p.b_ang = AB'(bang);
        return p;
    endfunction

    initial
    begin
        box_pair_t p;
        stim_done = 1'b0;
        hold_sender = 1'b0;
        // Axis-aligned overlap, touching edges, separated, zero sizes.
        queue_pair(simple_pair(0, 0, 512, 512, 0, 256, 0, 512, 512, 0));
        queue_pair(simple_pair(0, 0, 512, 512, 0, 512, 0, 512, 512, 0));
        queue_pair(simple_pair(0, 0, 512, 512, 0, 513, 0, 512, 512, 0));
        queue_pair(simple_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        queue_pair(simple_pair(100, 100, 0, 0, 0, 100, 100, 256, 256, 8192));
        // B below A, and left of it in the first pair: normal is flipped.
        queue_pair(simple_pair(0, 0, 1024, 1024, 0, -300, -100, 1024, 1024, 0));
        queue_pair(simple_pair(0, 0, 1024, 1024, 16384, 100, -300, 1024,
                               1024, 49152));
        // Equal overlap on several axes: first axis wins.
        queue_pair(simple_pair(0, 0, 1000, 1000, 0, 0, 0, 1000, 1000, 0));
        // Quadrant boundaries of the angle, and two octant angles.
        queue_pair(simple_pair(0, 0, 900, 300, 16383, 200, 100, 300, 900, 16385));
        queue_pair(simple_pair(0, 0, 900, 300, 32768, 200, 100, 300, 900, 49151));
        queue_pair(simple_pair(0, 0, 900, 300, 65535, 200, 100, 300, 900, 32767));
        queue_pair(simple_pair(0, 0, 900, 300, 8192, 200, 100, 300, 900, 24576));
        // Extremes: full sizes and coordinates, depth and contact saturation.
        queue_pair(simple_pair(-8388608, -8388608, 8388607, 8388607, 0,
                               8388607, 8388607, 8388607, 8388607, 0));
        queue_pair(simple_pair(8388607, 8388607, 8388607, 8388607, 8192,
                               8388607, 8388607, 8388607, 8388607, 40000));
        queue_pair(simple_pair(-8388608, -8388608, 8388607, 8388607, 12345,
                               -8388608, -8388608, 8388607, 8388607, 54321));
        queue_pair(simple_pair(-8388608, 8388607, 0, 0, 65535,
                               8388607, -8388608, 0, 0, 0));
        queue_pair(simple_pair(8388607, 0, 4000000, 8388607, 4096,
                               -8388608, 0, 8388607, 4000000, 61440));
        repeat (5) @(posedge clk);
        repeat (3) @(posedge clk);
        for (int i = 0; i < 690; i++)
        begin
            p = rand_pair();
            if ($urandom_range(0, 49) == 0)
            begin
                p.a_w = rand_size(1'b1);
                p.b_h = rand_size(1'b1);
            end
            queue_pair(p);
            if (i == 300)
            begin
                // Drain the pipe completely before resuming.
                wait (pending_pairs.size() == 0 && !in_ch.valid);
                hold_sender = 1'b1;
                wait (expected_contacts.size() == 0);
                @(posedge clk);
                hold_sender = 1'b0;
            end
            if (pending_pairs.size() > 40)
                wait (pending_pairs.size() < 10);
        end
        wait (pending_pairs.size() == 0 && !in_ch.valid);
        stim_done = 1'b1;
    end

    // Driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.a_center_x <= '0; in_ch.a_center_y <= '0;
            in_ch.a_width <= '0; in_ch.a_height <= '0; in_ch.a_angle <= '0;
            in_ch.b_center_x <= '0; in_ch.b_center_y <= '0;
            in_ch.b_width <= '0; in_ch.b_height <= '0; in_ch.b_angle <= '0;
            send_gap <= 0;
        end
        else if (!in_ch.valid || in_ch.ready)
        begin
            if (send_gap > 0)
            begin
                in_ch.valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_pairs.size() > 0 && !hold_sender)
            begin
                box_pair_t p;
                p = pending_pairs.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.a_center_x <= p.a_cx; in_ch.a_center_y <= p.a_cy;
                in_ch.a_width <= p.a_w; in_ch.a_height <= p.a_h; in_ch.a_angle <= p.a_ang;
                in_ch.b_center_x <= p.b_cx; in_ch.b_center_y <= p.b_cy;
                in_ch.b_width <= p.b_w; in_ch.b_height <= p.b_h; in_ch.b_angle <= p.b_ang;
                send_gap <= pick_gap();
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // Sink side stalls.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            take_gap <= 0;
        end
        else if (take_gap > 0)
        begin
            out_ch.ready <= 1'b0;
            take_gap <= take_gap - 1;
        end
        else
        begin
            out_ch.ready <= 1'b1;
            if (out_ch.valid && out_ch.ready)
                take_gap <= pick_gap();
        end
    end

    // Monitor: predict on input beats, compare on output beats.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            contact_t e;
            contact_t got;
            if (in_ch.valid && in_ch.ready)
            begin
                box_pair_t p;
                p = '{in_ch.a_center_x, in_ch.a_center_y, in_ch.a_width, in_ch.a_height,
                      in_ch.a_angle, in_ch.b_center_x, in_ch.b_center_y, in_ch.b_width,
                      in_ch.b_height, in_ch.b_angle};
                predict_contact(p, e);
                expected_contacts.insert(expected_contacts.size(), e);
            end
            if (out_ch.valid && out_ch.ready)
            begin
                got = '{out_ch.hit, out_ch.normal_x, out_ch.normal_y, out_ch.depth,
                        out_ch.contact_x, out_ch.contact_y};
                results_seen++;
                if (got.hit)
                    hits_seen++;
                if (expected_contacts.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: %p", got);
                end
                else
                begin
                    e = expected_contacts.pop_front();
                    if (got !== e)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p got %p", e, got);
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired, %0d results outstanding", expected_contacts.size());
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        mismatches = 0;
        hits_seen = 0;
        results_seen = 0;
        idle_cycles = 0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        wait (stim_done);
        wait (expected_contacts.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
        $display("checked %0d box pairs, %0d overlapping and %0d separated",
                 results_seen, hits_seen, results_seen - hits_seen);
        if (mismatches == 0 && expected_contacts.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
